@@ hw/rtl/mkc_pkg.sv @@
// ----------------------------------------------------------------------------
// mkc_pkg
// Types and constants shared by the motor keypad controller modules.
// ----------------------------------------------------------------------------
package mkc_pkg;

  localparam int KEYS_W   = 6;
  localparam int SPEED_W  = 11;
  localparam int TIME_W   = 10;
  localparam int STEP_W   = 8;
  localparam int HOLD_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam int KEY_TIME_INC  = 0;
  localparam int KEY_TIME_DEC  = 1;
  localparam int KEY_SPEED_INC = 2;
  localparam int KEY_SPEED_DEC = 3;
  localparam int KEY_START     = 4;
  localparam int KEY_HALT      = 5;

  localparam logic [TIME_W-1:0]  TIME_FINE   = 10'd1;
  localparam logic [TIME_W-1:0]  TIME_COARSE = 10'd10;
  localparam logic [TIME_W-1:0]  TIME_MAX    = 10'd1023;
  localparam logic [HOLD_W-1:0]  HOLD_MAX    = 4'd15;

  localparam logic [SPEED_W-1:0] RST_SPEED   = 11'd500;
  localparam logic [TIME_W-1:0]  RST_TIME    = 10'd10;

  localparam logic [STEP_W-1:0]  RST_SPEED_FINE   = 8'd10;
  localparam logic [STEP_W-1:0]  RST_SPEED_COARSE = 8'd50;
  localparam logic [SPEED_W-1:0] RST_SPEED_CEIL   = 11'd1750;
  localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR  = 11'd500;
  localparam logic [TIME_W-1:0]  RST_TIME_CEIL    = 10'd900;
  localparam logic [TIME_W-1:0]  RST_TIME_FLOOR   = 10'd10;
  localparam logic [HOLD_W-1:0]  RST_HOLD_THR     = 4'd6;
  localparam logic [HOLD_W-1:0]  RST_START_SCANS  = 4'd1;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_RUN   = 2'd2,
    OP_ERROR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    MODE_STOP     = 3'd0,
    MODE_STARTING = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_PAUSED   = 3'd3,
    MODE_ERROR    = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_FINE   = 3'd0,
    CFG_SPEED_COARSE = 3'd1,
    CFG_SPEED_CEIL   = 3'd2,
    CFG_SPEED_FLOOR  = 3'd3,
    CFG_TIME_CEIL    = 3'd4,
    CFG_TIME_FLOOR   = 3'd5,
    CFG_HOLD_THR     = 3'd6,
    CFG_START_SCANS  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [KEYS_W-1:0]  keys;
    logic [SPEED_W-1:0] saved_speed;
    logic [TIME_W-1:0]  saved_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         motor_mode;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  preset_time;
    logic [TIME_W-1:0]  run_period;
    logic               pwm_update;
    logic               save_request;
    logic               display_refresh;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  speed_fine_step;
    logic [STEP_W-1:0]  speed_coarse_step;
    logic [SPEED_W-1:0] speed_ceiling;
    logic [SPEED_W-1:0] speed_floor;
    logic [TIME_W-1:0]  time_ceiling;
    logic [TIME_W-1:0]  time_floor;
    logic [HOLD_W-1:0]  hold_threshold;
    logic [HOLD_W-1:0]  start_hold_scans;
  } cfg_regs_t;

  typedef struct packed {
    logic [HOLD_W-1:0] cnt;
    logic              fast;
  } hold_t;

  typedef struct packed {
    logic [KEYS_W-1:0]  prev_keys;
    hold_t              hold;
    mode_t              mode;
    logic [SPEED_W-1:0] speed;
    logic [TIME_W-1:0]  preset;
    logic [TIME_W-1:0]  run_period;
  } ctl_state_t;

endpackage

@@ hw/rtl/mkc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mkc_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module mkc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [mkc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [mkc_pkg::CFG_DATA_W-1:0]    wr_data,
  output mkc_pkg::cfg_regs_t                cfg
);

  mkc_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (mkc_pkg::cfg_idx_t'(wr_index))
        mkc_pkg::CFG_SPEED_FINE:   cfg_nxt.speed_fine_step   = wr_data[mkc_pkg::STEP_W-1:0];
        mkc_pkg::CFG_SPEED_COARSE: cfg_nxt.speed_coarse_step = wr_data[mkc_pkg::STEP_W-1:0];
        mkc_pkg::CFG_SPEED_CEIL:   cfg_nxt.speed_ceiling     = wr_data[mkc_pkg::SPEED_W-1:0];
        mkc_pkg::CFG_SPEED_FLOOR:  cfg_nxt.speed_floor       = wr_data[mkc_pkg::SPEED_W-1:0];
        mkc_pkg::CFG_TIME_CEIL:    cfg_nxt.time_ceiling      = wr_data[mkc_pkg::TIME_W-1:0];
        mkc_pkg::CFG_TIME_FLOOR:   cfg_nxt.time_floor        = wr_data[mkc_pkg::TIME_W-1:0];
        mkc_pkg::CFG_HOLD_THR:     cfg_nxt.hold_threshold    = wr_data[mkc_pkg::HOLD_W-1:0];
        mkc_pkg::CFG_START_SCANS:  cfg_nxt.start_hold_scans  = wr_data[mkc_pkg::HOLD_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_fine_step   <= mkc_pkg::RST_SPEED_FINE;
      cfg_r.speed_coarse_step <= mkc_pkg::RST_SPEED_COARSE;
      cfg_r.speed_ceiling     <= mkc_pkg::RST_SPEED_CEIL;
      cfg_r.speed_floor       <= mkc_pkg::RST_SPEED_FLOOR;
      cfg_r.time_ceiling      <= mkc_pkg::RST_TIME_CEIL;
      cfg_r.time_floor        <= mkc_pkg::RST_TIME_FLOOR;
      cfg_r.hold_threshold    <= mkc_pkg::RST_HOLD_THR;
      cfg_r.start_hold_scans  <= mkc_pkg::RST_START_SCANS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/mkc_step.sv @@
// ----------------------------------------------------------------------------
// mkc_step
// Next-state and result logic for one operation (scan, load, run, error).
// ----------------------------------------------------------------------------
module mkc_step (
  input  mkc_pkg::in_item_t   item,
  input  mkc_pkg::cfg_regs_t  cfg,
  input  mkc_pkg::ctl_state_t cur,
  output mkc_pkg::ctl_state_t nxt,
  output mkc_pkg::out_item_t  res
);

  function automatic mkc_pkg::hold_t hold_step(
    input logic                        fresh,
    input mkc_pkg::hold_t              h_in,
    input logic [mkc_pkg::HOLD_W-1:0]  thr
  );
    mkc_pkg::hold_t h;
    h = h_in;
    if (fresh) begin
      h = '0;
    end
    if (h.cnt <= thr) begin
      h.fast = 1'b0;
      if (h.cnt != mkc_pkg::HOLD_MAX) begin
        h.cnt = h.cnt + 4'd1;
      end
    end else begin
      h.fast = 1'b1;
    end
    return h;
  endfunction

  logic                          fresh;
  logic                          pwm, save, disp;
  logic [mkc_pkg::TIME_W:0]      t_sum;
  logic [mkc_pkg::TIME_W-1:0]    t_dec;
  logic [mkc_pkg::SPEED_W:0]     s_sum;
  logic [mkc_pkg::STEP_W-1:0]    s_step;
  logic [mkc_pkg::SPEED_W-1:0]   s_dec;
  logic [mkc_pkg::SPEED_W-1:0]   s_diff;
  mkc_pkg::ctl_state_t           st;

  always_comb begin
    st     = cur;
    pwm    = 1'b0;
    save   = 1'b0;
    disp   = 1'b0;
    fresh  = |(item.keys & ~cur.prev_keys);
    t_sum  = '0;
    t_dec  = '0;
    s_sum  = '0;
    s_step = '0;
    s_dec  = '0;
    s_diff = '0;

    unique case (mkc_pkg::op_t'(item.op))
      mkc_pkg::OP_SCAN: begin
        st.prev_keys = item.keys;

        if (item.keys[mkc_pkg::KEY_HALT] && st.mode != mkc_pkg::MODE_STOP) begin
          if (st.mode == mkc_pkg::MODE_RUNNING) begin
            st.mode = mkc_pkg::MODE_PAUSED;
          end else begin
            st.mode       = mkc_pkg::MODE_STOP;
            st.run_period = st.preset;
          end
          disp = 1'b1;
        end

        if (item.keys[mkc_pkg::KEY_START]) begin
          if (fresh) begin
            st.hold.cnt = '0;
          end
          if (st.hold.cnt < cfg.start_hold_scans) begin
            st.hold.cnt = st.hold.cnt + 4'd1;
          end else if (st.mode == mkc_pkg::MODE_STOP) begin
            st.run_period = st.preset;
            st.mode       = mkc_pkg::MODE_STARTING;
            disp          = 1'b1;
          end
        end

        if (item.keys[mkc_pkg::KEY_TIME_INC] && st.mode == mkc_pkg::MODE_STOP) begin
          st.hold = hold_step(fresh, st.hold, cfg.hold_threshold);
          if (st.preset >= cfg.time_ceiling) begin
            st.preset = cfg.time_ceiling;
          end else begin
            t_sum = {1'b0, st.preset}
                  + {1'b0, (st.hold.fast ? mkc_pkg::TIME_COARSE : mkc_pkg::TIME_FINE)};
            st.preset = t_sum[mkc_pkg::TIME_W] ? mkc_pkg::TIME_MAX
                                                : t_sum[mkc_pkg::TIME_W-1:0];
          end
          st.run_period = st.preset;
          save = 1'b1;
          disp = 1'b1;
        end

        if (item.keys[mkc_pkg::KEY_TIME_DEC] && st.mode == mkc_pkg::MODE_STOP) begin
          st.hold = hold_step(fresh, st.hold, cfg.hold_threshold);
          t_dec = st.hold.fast ? mkc_pkg::TIME_COARSE : mkc_pkg::TIME_FINE;
          if (st.preset <= cfg.time_floor) begin
            st.preset = cfg.time_floor;
          end else if (st.preset > t_dec) begin
            st.preset = st.preset - t_dec;
          end else begin
            st.preset = '0;
          end
          st.run_period = st.preset;
          save = 1'b1;
          disp = 1'b1;
        end

        if (item.keys[mkc_pkg::KEY_SPEED_INC]) begin
          st.hold = hold_step(fresh, st.hold, cfg.hold_threshold);
          s_step = st.hold.fast ? cfg.speed_coarse_step : cfg.speed_fine_step;
          s_sum  = {1'b0, st.speed} + {4'b0, s_step};
          if (s_sum[mkc_pkg::SPEED_W] || s_sum >= {1'b0, cfg.speed_ceiling}) begin
            st.speed = cfg.speed_ceiling;
          end else begin
            st.speed = s_sum[mkc_pkg::SPEED_W-1:0];
          end
          pwm  = pwm  | (st.mode == mkc_pkg::MODE_RUNNING);
          save = save | (st.mode == mkc_pkg::MODE_STOP);
          disp = 1'b1;
        end

        if (item.keys[mkc_pkg::KEY_SPEED_DEC]) begin
          st.hold = hold_step(fresh, st.hold, cfg.hold_threshold);
          s_dec  = {3'b0, (st.hold.fast ? cfg.speed_coarse_step : cfg.speed_fine_step)};
          s_diff = st.speed - s_dec;
          if (st.speed < s_dec || s_diff <= cfg.speed_floor) begin
            st.speed = cfg.speed_floor;
          end else begin
            st.speed = s_diff;
          end
          pwm  = pwm  | (st.mode == mkc_pkg::MODE_RUNNING);
          save = save | (st.mode == mkc_pkg::MODE_STOP);
          disp = 1'b1;
        end
      end
      mkc_pkg::OP_LOAD: begin
        st.speed      = item.saved_speed;
        st.preset     = item.saved_time;
        st.run_period = item.saved_time;
      end
      mkc_pkg::OP_RUN: begin
        if (st.mode == mkc_pkg::MODE_STARTING) begin
          st.mode = mkc_pkg::MODE_RUNNING;
        end
      end
      mkc_pkg::OP_ERROR: begin
        st.mode = mkc_pkg::MODE_ERROR;
      end
      default: st = cur;
    endcase

    nxt                 = st;
    res.motor_mode      = st.mode;
    res.speed           = st.speed;
    res.preset_time     = st.preset;
    res.run_period      = st.run_period;
    res.pwm_update      = pwm;
    res.save_request    = save;
    res.display_refresh = disp;
  end

endmodule

@@ hw/rtl/motor_keypad_controller.sv @@
// ----------------------------------------------------------------------------
// motor_keypad_controller
// Keypad front end of a small motor controller: key scans, saved-setting
// loads and motor events update mode, speed and times, one result each.
//
//   channel | ports                          | transaction
//   --------+--------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data    | one operation (in_item_t)
//   out     | out_valid, out_ready, out_data | one result (out_item_t)
//   cfg     | cfg_valid, cfg_ready,          | one register write
//           | cfg_index, cfg_data            |
//
// Input register, then update logic into the state and result registers.
// One transaction per cycle sustained while out_ready is high.
// in_ready drops only while the input register holds an operation that the
// full, unread result register blocks. cfg_ready is always high.
// Synchronous active-low reset restores register defaults and state.
// ----------------------------------------------------------------------------
module motor_keypad_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mkc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mkc_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mkc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mkc_pkg::cfg_regs_t  cfg;
  mkc_pkg::ctl_state_t state_r, state_nxt;
  mkc_pkg::out_item_t  res_nxt, out_r;
  mkc_pkg::in_item_t   in_r;
  logic                in_vld_r, out_vld_r;
  logic                advance;

  assign cfg_ready = 1'b1;

  mkc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mkc_step u_step (
    .item (in_r),
    .cfg  (cfg),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r          <= 1'b0;
      state_r.prev_keys  <= '0;
      state_r.hold       <= '0;
      state_r.mode       <= mkc_pkg::MODE_STOP;
      state_r.speed      <= mkc_pkg::RST_SPEED;
      state_r.preset     <= mkc_pkg::RST_TIME;
      state_r.run_period <= mkc_pkg::RST_TIME;
    end else if (advance) begin
      out_vld_r <= 1'b1;
      state_r   <= state_nxt;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ bench/motor_keypad_controller_tb.sv @@
// ----------------------------------------------------------------------------
// motor_keypad_controller_tb
// Self-checking bench for the motor keypad controller. A directed table covers
// reset state, error recovery, clamps, saturation and register masking; random
// phases follow under several register settings, mostly well-formed key
// sequences (holds, start/run/stop cycles, loads) with some noise. Each result
// is checked field by field against an in-bench model, typed rows against the
// table, with random input gaps and random stalls on the result side.
// ----------------------------------------------------------------------------
module motor_keypad_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mkc_pkg::*;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
    cfg_idx_t         idx;
    logic [10:0]      wdata;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = CFG_SPEED_FINE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // controller model state
  cfg_regs_t           kp_cfg;
  logic [KEYS_W-1:0]   kp_prev;
  logic [HOLD_W-1:0]   kp_hold;
  logic                kp_fast;
  mode_t               kp_mode;
  logic [SPEED_W-1:0]  kp_speed;
  logic [TIME_W-1:0]   kp_preset;
  logic [TIME_W-1:0]   kp_run;

  out_item_t due_status[$];
  dir_row_t  dir_tab[$];
  out_item_t rx_want;
  int        errors = 0;
  int        n_sent = 0;
  int        tx_gap_pct = 25;
  int        rx_stall_pct = 25;
  int        rx_hold = 0;

  motor_keypad_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_error(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void hold_advance(bit fresh);
    if (fresh) begin
      kp_fast = 1'b0;
      kp_hold = '0;
    end
    if (kp_hold <= kp_cfg.hold_threshold) begin
      kp_fast = 1'b0;
      if (kp_hold != HOLD_MAX) kp_hold++;
    end else begin
      kp_fast = 1'b1;
    end
  endfunction

  function automatic out_item_t apply_operation(in_item_t it);
    out_item_t r;
    logic [KEYS_W-1:0] k;
    bit fresh;
    int t, s, d;
    r = '0;
    case (op_t'(it.op))
      OP_SCAN: begin
        k = it.keys;
        fresh = (k & ~kp_prev) != '0;
        kp_prev = k;
        if (k[KEY_HALT] && kp_mode != MODE_STOP) begin
          if (kp_mode == MODE_RUNNING) begin
            kp_mode = MODE_PAUSED;
          end else if (kp_mode == MODE_PAUSED || kp_mode == MODE_ERROR ||
                       kp_mode == MODE_STARTING) begin
            kp_mode = MODE_STOP;
            kp_run = kp_preset;
          end
          r.display_refresh = 1'b1;
        end
        if (k[KEY_START]) begin
          if (fresh) kp_hold = '0;
          if (kp_hold < kp_cfg.start_hold_scans) begin
            kp_hold++;
          end else if (kp_mode == MODE_STOP) begin
            kp_run = kp_preset;
            kp_mode = MODE_STARTING;
            r.display_refresh = 1'b1;
          end
        end
        if (k[KEY_TIME_INC] && kp_mode == MODE_STOP) begin
          hold_advance(fresh);
          if (kp_preset >= kp_cfg.time_ceiling) begin
            kp_preset = kp_cfg.time_ceiling;
          end else begin
            t = int'(kp_preset) + (kp_fast ? int'(TIME_COARSE) : int'(TIME_FINE));
            kp_preset = (t > int'(TIME_MAX)) ? TIME_MAX : TIME_W'(t);
          end
          kp_run = kp_preset;
          r.save_request = 1'b1;
          r.display_refresh = 1'b1;
        end
        if (k[KEY_TIME_DEC] && kp_mode == MODE_STOP) begin
          hold_advance(fresh);
          if (kp_preset <= kp_cfg.time_floor) begin
            kp_preset = kp_cfg.time_floor;
          end else begin
            d = kp_fast ? int'(TIME_COARSE) : int'(TIME_FINE);
            kp_preset = (int'(kp_preset) > d) ? TIME_W'(int'(kp_preset) - d) : '0;
          end
          kp_run = kp_preset;
          r.save_request = 1'b1;
          r.display_refresh = 1'b1;
        end
        if (k[KEY_SPEED_INC]) begin
          hold_advance(fresh);
          s = int'(kp_speed) +
              int'(kp_fast ? kp_cfg.speed_coarse_step : kp_cfg.speed_fine_step);
          if (s >= int'(kp_cfg.speed_ceiling) || s > (1 << SPEED_W) - 1)
            s = int'(kp_cfg.speed_ceiling);
          kp_speed = SPEED_W'(s);
          if (kp_mode == MODE_RUNNING) r.pwm_update = 1'b1;
          if (kp_mode == MODE_STOP) r.save_request = 1'b1;
          r.display_refresh = 1'b1;
        end
        if (k[KEY_SPEED_DEC]) begin
          hold_advance(fresh);
          d = int'(kp_fast ? kp_cfg.speed_coarse_step : kp_cfg.speed_fine_step);
          if (int'(kp_speed) < d || int'(kp_speed) - d <= int'(kp_cfg.speed_floor))
            kp_speed = kp_cfg.speed_floor;
          else
            kp_speed = SPEED_W'(int'(kp_speed) - d);
          if (kp_mode == MODE_RUNNING) r.pwm_update = 1'b1;
          if (kp_mode == MODE_STOP) r.save_request = 1'b1;
          r.display_refresh = 1'b1;
        end
      end
      OP_LOAD: begin
        kp_speed = it.saved_speed;
        kp_preset = it.saved_time;
        kp_run = kp_preset;
      end
      OP_RUN: begin
        if (kp_mode == MODE_STARTING) kp_mode = MODE_RUNNING;
      end
      default: kp_mode = MODE_ERROR;
    endcase
    r.motor_mode = kp_mode;
    r.speed = kp_speed;
    r.preset_time = kp_preset;
    r.run_period = kp_run;
    return r;
  endfunction

  function automatic in_item_t make_item(op_t op, logic [KEYS_W-1:0] k);
    in_item_t it;
    it.op = op;
    it.keys = k;
    case ($urandom_range(0, 5))
      0: it.saved_speed = '0;
      1: it.saved_speed = '1;
      default: it.saved_speed = SPEED_W'($urandom_range(0, 2047));
    endcase
    case ($urandom_range(0, 5))
      0: it.saved_time = '0;
      1: it.saved_time = '1;
      default: it.saved_time = TIME_W'($urandom_range(0, 1023));
    endcase
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t predicted;
    if (cfg_valid) cfg_valid <= 1'b0;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_operation(it);
    due_status.push_back(typed ? want : predicted);
    n_sent++;
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    if (in_valid) in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SPEED_FINE:   kp_cfg.speed_fine_step = data[STEP_W-1:0];
      CFG_SPEED_COARSE: kp_cfg.speed_coarse_step = data[STEP_W-1:0];
      CFG_SPEED_CEIL:   kp_cfg.speed_ceiling = data[SPEED_W-1:0];
      CFG_SPEED_FLOOR:  kp_cfg.speed_floor = data[SPEED_W-1:0];
      CFG_TIME_CEIL:    kp_cfg.time_ceiling = data[TIME_W-1:0];
      CFG_TIME_FLOOR:   kp_cfg.time_floor = data[TIME_W-1:0];
      CFG_HOLD_THR:     kp_cfg.hold_threshold = data[HOLD_W-1:0];
      CFG_START_SCANS:  kp_cfg.start_hold_scans = data[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register width are random to exercise masking
  task automatic load_settings(cfg_regs_t st);
    cfg_write(CFG_SPEED_FINE, {3'($urandom), st.speed_fine_step});
    cfg_write(CFG_SPEED_COARSE, {3'($urandom), st.speed_coarse_step});
    cfg_write(CFG_SPEED_CEIL, st.speed_ceiling);
    cfg_write(CFG_SPEED_FLOOR, st.speed_floor);
    cfg_write(CFG_TIME_CEIL, {1'($urandom), st.time_ceiling});
    cfg_write(CFG_TIME_FLOOR, {1'($urandom), st.time_floor});
    cfg_write(CFG_HOLD_THR, {7'($urandom), st.hold_threshold});
    cfg_write(CFG_START_SCANS, {7'($urandom), st.start_hold_scans});
  endtask

  task automatic row_item(op_t op, logic [KEYS_W-1:0] k, logic [SPEED_W-1:0] sp,
                          logic [TIME_W-1:0] tm);
    dir_row_t row;
    row.kind = ROW_ITEM;
    row.item = '{op: op, keys: k, saved_speed: sp, saved_time: tm};
    row.typed = 1'b0;
    row.want = '0;
    row.idx = CFG_SPEED_FINE;
    row.wdata = '0;
    dir_tab.push_back(row);
  endtask

  task automatic row_typed(op_t op, logic [KEYS_W-1:0] k, logic [SPEED_W-1:0] sp,
                           logic [TIME_W-1:0] tm, mode_t m, logic [SPEED_W-1:0] s,
                           logic [TIME_W-1:0] p, logic [TIME_W-1:0] r,
                           logic [2:0] flags);
    row_item(op, k, sp, tm);
    dir_tab[$].typed = 1'b1;
    dir_tab[$].want = {m, s, p, r, flags};
  endtask

  task automatic row_cfg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    row_item(OP_SCAN, '0, '0, '0);
    dir_tab[$].kind = ROW_CFG;
    dir_tab[$].idx = idx;
    dir_tab[$].wdata = data;
  endtask

  task automatic random_sequence();
    logic [KEYS_W-1:0] k;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // held adjust keys
      case ($urandom_range(0, 5))
        0: k = KEYS_W'(1 << KEY_TIME_INC);
        1: k = KEYS_W'(1 << KEY_TIME_DEC);
        2: k = KEYS_W'(1 << KEY_SPEED_INC);
        3: k = KEYS_W'(1 << KEY_SPEED_DEC);
        default: k = KEYS_W'($urandom_range(1, 63));
      endcase
      if ($urandom_range(0, 1)) send_item(make_item(OP_SCAN, '0));
      repeat ($urandom_range(1, 20)) send_item(make_item(OP_SCAN, k));
    end else if (pick < 70) begin
      // start, reach run, adjust speed, pause, stop
      send_item(make_item(OP_SCAN, '0));
      k = KEYS_W'(1 << KEY_START);
      if ($urandom_range(0, 3) == 0) k |= KEYS_W'($urandom_range(0, 15));
      repeat ($urandom_range(1, int'(kp_cfg.start_hold_scans) + 2))
        send_item(make_item(OP_SCAN, k));
      if ($urandom_range(0, 4) != 0) send_item(make_item(OP_RUN, KEYS_W'($urandom)));
      repeat ($urandom_range(0, 6))
        send_item(make_item(OP_SCAN, $urandom_range(0, 1) ?
                            KEYS_W'(1 << KEY_SPEED_INC) : KEYS_W'(1 << KEY_SPEED_DEC)));
      if ($urandom_range(0, 5) == 0) send_item(make_item(OP_ERROR, KEYS_W'($urandom)));
      repeat ($urandom_range(1, 3)) send_item(make_item(OP_SCAN, KEYS_W'(1 << KEY_HALT)));
    end else if (pick < 80) begin
      send_item(make_item(OP_LOAD, KEYS_W'($urandom)));
    end else if (pick < 88) begin
      send_item(make_item(OP_ERROR, KEYS_W'($urandom)));
      if ($urandom_range(0, 1)) send_item(make_item(OP_SCAN, KEYS_W'(1 << KEY_HALT)));
    end else begin
      send_item(make_item(op_t'($urandom_range(0, 3)), KEYS_W'($urandom)));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_status.size() == 0) begin
        report_error($sformatf("unexpected result %h", out_data));
      end else begin
        rx_want = due_status.pop_front();
        if (out_data.motor_mode !== rx_want.motor_mode)
          report_error($sformatf("motor_mode %0d, expected %0d",
                                 out_data.motor_mode, rx_want.motor_mode));
        if (out_data.speed !== rx_want.speed)
          report_error($sformatf("speed %0d, expected %0d", out_data.speed, rx_want.speed));
        if (out_data.preset_time !== rx_want.preset_time)
          report_error($sformatf("preset_time %0d, expected %0d",
                                 out_data.preset_time, rx_want.preset_time));
        if (out_data.run_period !== rx_want.run_period)
          report_error($sformatf("run_period %0d, expected %0d",
                                 out_data.run_period, rx_want.run_period));
        if (out_data.pwm_update !== rx_want.pwm_update)
          report_error($sformatf("pwm_update %b, expected %b",
                                 out_data.pwm_update, rx_want.pwm_update));
        if (out_data.save_request !== rx_want.save_request)
          report_error($sformatf("save_request %b, expected %b",
                                 out_data.save_request, rx_want.save_request));
        if (out_data.display_refresh !== rx_want.display_refresh)
          report_error($sformatf("display_refresh %b, expected %b",
                                 out_data.display_refresh, rx_want.display_refresh));
      end
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < rx_stall_pct) rx_hold = gap_len();
    end
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_regs_t setting;
    int target;

    kp_cfg = '{speed_fine_step: RST_SPEED_FINE, speed_coarse_step: RST_SPEED_COARSE,
               speed_ceiling: RST_SPEED_CEIL, speed_floor: RST_SPEED_FLOOR,
               time_ceiling: RST_TIME_CEIL, time_floor: RST_TIME_FLOOR,
               hold_threshold: RST_HOLD_THR, start_hold_scans: RST_START_SCANS};
    kp_prev = '0;
    kp_hold = '0;
    kp_fast = 1'b0;
    kp_mode = MODE_STOP;
    kp_speed = RST_SPEED;
    kp_preset = RST_TIME;
    kp_run = RST_TIME;

    row_typed(OP_SCAN, 6'h00, 0, 0, MODE_STOP, 500, 10, 10, 3'b000);
    row_typed(OP_ERROR, 6'h00, 0, 0, MODE_ERROR, 500, 10, 10, 3'b000);
    row_typed(OP_SCAN, 6'h20, 0, 0, MODE_STOP, 500, 10, 10, 3'b001);
    row_typed(OP_LOAD, 6'h00, 2047, 1023, MODE_STOP, 2047, 1023, 1023, 3'b000);
    row_typed(OP_SCAN, 6'h04, 0, 0, MODE_STOP, 1750, 1023, 1023, 3'b011);
    row_typed(OP_SCAN, 6'h01, 0, 0, MODE_STOP, 1750, 900, 900, 3'b011);
    row_typed(OP_LOAD, 6'h3F, 0, 0, MODE_STOP, 0, 0, 0, 3'b000);
    row_typed(OP_SCAN, 6'h0A, 0, 0, MODE_STOP, 500, 10, 10, 3'b011);
    row_item(OP_SCAN, 6'h10, 0, 0);
    row_item(OP_SCAN, 6'h10, 0, 0);
    row_item(OP_RUN, 6'h00, 0, 0);
    row_item(OP_SCAN, 6'h0C, 0, 0);
    row_item(OP_SCAN, 6'h21, 0, 0);
    row_item(OP_RUN, 6'h00, 0, 0);
    row_item(OP_SCAN, 6'h20, 0, 0);
    row_item(OP_SCAN, 6'h10, 0, 0);
    row_item(OP_SCAN, 6'h10, 0, 0);
    row_item(OP_SCAN, 6'h30, 0, 0);
    row_item(OP_SCAN, 6'h3F, 0, 0);
    row_item(OP_SCAN, 6'h00, 0, 0);
    row_cfg(CFG_SPEED_FINE, 11'h7FF);
    row_cfg(CFG_SPEED_COARSE, 11'h7FF);
    row_cfg(CFG_SPEED_CEIL, 11'd0);
    row_cfg(CFG_SPEED_FLOOR, 11'd2047);
    row_cfg(CFG_TIME_CEIL, 11'h7FF);
    row_cfg(CFG_TIME_FLOOR, 11'h400);
    row_cfg(CFG_HOLD_THR, 11'h7F0);
    row_cfg(CFG_START_SCANS, 11'h7F0);
    row_item(OP_LOAD, 6'h00, 2047, 1020);
    row_item(OP_SCAN, 6'h01, 0, 0);
    row_typed(OP_SCAN, 6'h01, 0, 0, MODE_STOP, 2047, 1023, 1023, 3'b011);
    row_item(OP_LOAD, 6'h00, 2047, 5);
    row_item(OP_SCAN, 6'h02, 0, 0);
    row_typed(OP_SCAN, 6'h02, 0, 0, MODE_STOP, 2047, 0, 0, 3'b011);
    row_item(OP_SCAN, 6'h18, 0, 0);
    row_item(OP_ERROR, 6'h00, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) cfg_write(dir_tab[i].idx, dir_tab[i].wdata);
      else send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setting = '{RST_SPEED_FINE, RST_SPEED_COARSE, RST_SPEED_CEIL, RST_SPEED_FLOOR,
                       RST_TIME_CEIL, RST_TIME_FLOOR, RST_HOLD_THR, RST_START_SCANS};
        1: setting = '{8'd255, 8'd255, 11'd2047, 11'd0, 10'd1023, 10'd0, 4'd15, 4'd15};
        2: setting = '0;
        default: begin
          setting.speed_fine_step = STEP_W'($urandom_range(0, 255));
          setting.speed_coarse_step = STEP_W'($urandom_range(0, 255));
          setting.speed_ceiling = SPEED_W'($urandom_range(900, 2047));
          setting.speed_floor = SPEED_W'($urandom_range(0, 1000));
          setting.time_ceiling = TIME_W'($urandom_range(50, 1023));
          setting.time_floor = TIME_W'($urandom_range(0, 100));
          setting.hold_threshold = HOLD_W'($urandom_range(0, 15));
          setting.start_hold_scans = HOLD_W'($urandom_range(0, 3));
        end
      endcase
      tx_gap_pct = (ph == 4) ? 0 : $urandom_range(5, 40);
      rx_stall_pct = (ph == 3) ? 0 : $urandom_range(5, 40);
      load_settings(setting);
      target = n_sent + 300;
      while (n_sent < target) random_sequence();
    end

    if (in_valid) in_valid <= 1'b0;
    while (due_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
